@@ src/lmp_pkg.sv @@
// Shared types and codes for the length-prefixed message parser.
package lmp_pkg;

  localparam logic [3:0] ROLE_TYPE    = 4'd0;
  localparam logic [3:0] ROLE_COUNT   = 4'd1;
  localparam logic [3:0] ROLE_KEYLEN  = 4'd2;
  localparam logic [3:0] ROLE_KEY     = 4'd3;
  localparam logic [3:0] ROLE_VALLEN  = 4'd4;
  localparam logic [3:0] ROLE_VALUE   = 4'd5;
  localparam logic [3:0] ROLE_BODYLEN = 4'd6;
  localparam logic [3:0] ROLE_BODY    = 4'd7;
  localparam logic [3:0] ROLE_IGNORED = 4'd8;

  localparam logic [1:0] STAT_BUSY  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  typedef struct packed {
    logic [3:0]  role;
    logic [7:0]  byte_out;
    logic [15:0] header_number;
    logic        field_done;
    logic [1:0]  status;
  } lmp_res_t;

endpackage

@@ src/lmp_if.sv @@
// Valid/ready channel interfaces for input bytes and tagged result beats.
interface lmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface lmp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  role;
  logic [7:0]  byte_out;
  logic [15:0] header_number;
  logic        field_done;
  logic [1:0]  status;

  modport source (output valid, output role, output byte_out, output header_number,
                  output field_done, output status, input ready);
  modport sink (input valid, input role, input byte_out, input header_number,
                input field_done, input status, output ready);
endinterface

@@ src/lmp_core.sv @@
// Parser state registers and the per-byte tagging logic.
module lmp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                buffer_end,
  output lmp_pkg::lmp_res_t   res
);

  localparam logic [3:0] PH_TYPE     = 4'd0;
  localparam logic [3:0] PH_COUNT_LO = 4'd1;
  localparam logic [3:0] PH_COUNT_HI = 4'd2;
  localparam logic [3:0] PH_KLEN_LO  = 4'd3;
  localparam logic [3:0] PH_KLEN_HI  = 4'd4;
  localparam logic [3:0] PH_KEY      = 4'd5;
  localparam logic [3:0] PH_VLEN_LO  = 4'd6;
  localparam logic [3:0] PH_VLEN_HI  = 4'd7;
  localparam logic [3:0] PH_VALUE    = 4'd8;
  localparam logic [3:0] PH_BLEN_LO  = 4'd9;
  localparam logic [3:0] PH_BLEN_HI  = 4'd10;
  localparam logic [3:0] PH_BODY     = 4'd11;
  localparam logic [3:0] PH_DONE     = 4'd12;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] headers_left_r, headers_left_nxt;
  logic [15:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  low_half_r, low_half_nxt;
  logic [15:0] word;
  logic [15:0] left_dec;
  logic [3:0]  close_phase;

  assign word        = {data_byte, low_half_r};
  assign left_dec    = bytes_left_r - 16'd1;
  // after the last header the body length follows
  assign close_phase = (headers_left_r != 16'd1) ? PH_KLEN_LO : PH_BLEN_LO;

  always_comb begin
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    headers_left_nxt = headers_left_r;
    hdr_cnt_nxt      = hdr_cnt_r;
    low_half_nxt     = low_half_r;
    res.role          = lmp_pkg::ROLE_IGNORED;
    res.byte_out      = data_byte;
    res.header_number = 16'd0;
    res.field_done    = 1'b0;
    res.status        = lmp_pkg::STAT_BUSY;

    case (phase_r)
      PH_TYPE: begin
        res.role       = lmp_pkg::ROLE_TYPE;
        res.field_done = 1'b1;
        phase_nxt      = PH_COUNT_LO;
      end
      PH_COUNT_LO: begin
        res.role     = lmp_pkg::ROLE_COUNT;
        low_half_nxt = data_byte;
        phase_nxt    = PH_COUNT_HI;
      end
      PH_COUNT_HI: begin
        res.role         = lmp_pkg::ROLE_COUNT;
        res.field_done   = 1'b1;
        headers_left_nxt = word;
        hdr_cnt_nxt      = 16'd0;
        phase_nxt        = (word != 16'd0) ? PH_KLEN_LO : PH_BLEN_LO;
      end
      PH_KLEN_LO: begin
        res.role          = lmp_pkg::ROLE_KEYLEN;
        res.header_number = hdr_cnt_r;
        low_half_nxt      = data_byte;
        phase_nxt         = PH_KLEN_HI;
      end
      PH_KLEN_HI: begin
        res.role          = lmp_pkg::ROLE_KEYLEN;
        res.header_number = hdr_cnt_r;
        res.field_done    = 1'b1;
        bytes_left_nxt    = word;
        phase_nxt         = (word != 16'd0) ? PH_KEY : PH_VLEN_LO;
      end
      PH_KEY: begin
        res.role          = lmp_pkg::ROLE_KEY;
        res.header_number = hdr_cnt_r;
        bytes_left_nxt    = left_dec;
        if (left_dec == 16'd0) begin
          res.field_done = 1'b1;
          phase_nxt      = PH_VLEN_LO;
        end
      end
      PH_VLEN_LO: begin
        res.role          = lmp_pkg::ROLE_VALLEN;
        res.header_number = hdr_cnt_r;
        low_half_nxt      = data_byte;
        phase_nxt         = PH_VLEN_HI;
      end
      PH_VLEN_HI: begin
        res.role          = lmp_pkg::ROLE_VALLEN;
        res.header_number = hdr_cnt_r;
        res.field_done    = 1'b1;
        bytes_left_nxt    = word;
        if (word != 16'd0) begin
          phase_nxt = PH_VALUE;
        end else begin
          hdr_cnt_nxt      = hdr_cnt_r + 16'd1;
          headers_left_nxt = headers_left_r - 16'd1;
          phase_nxt        = close_phase;
        end
      end
      PH_VALUE: begin
        res.role          = lmp_pkg::ROLE_VALUE;
        res.header_number = hdr_cnt_r;
        bytes_left_nxt    = left_dec;
        if (left_dec == 16'd0) begin
          res.field_done   = 1'b1;
          hdr_cnt_nxt      = hdr_cnt_r + 16'd1;
          headers_left_nxt = headers_left_r - 16'd1;
          phase_nxt        = close_phase;
        end
      end
      PH_BLEN_LO: begin
        res.role     = lmp_pkg::ROLE_BODYLEN;
        low_half_nxt = data_byte;
        phase_nxt    = PH_BLEN_HI;
      end
      PH_BLEN_HI: begin
        res.role       = lmp_pkg::ROLE_BODYLEN;
        res.field_done = 1'b1;
        bytes_left_nxt = word;
        if (word != 16'd0) begin
          phase_nxt = PH_BODY;
        end else begin
          phase_nxt  = PH_DONE;
          res.status = lmp_pkg::STAT_DONE;
        end
      end
      PH_BODY: begin
        res.role       = lmp_pkg::ROLE_BODY;
        bytes_left_nxt = left_dec;
        if (left_dec == 16'd0) begin
          res.field_done = 1'b1;
          phase_nxt      = PH_DONE;
          res.status     = lmp_pkg::STAT_DONE;
        end
      end
      default: begin
        // completed message, and unreachable codes
        res.status = lmp_pkg::STAT_DONE;
      end
    endcase

    // buffer end: flag truncation and start over on the next beat
    if (buffer_end) begin
      if (res.status == lmp_pkg::STAT_BUSY) begin
        res.status = lmp_pkg::STAT_TRUNC;
      end
      phase_nxt        = PH_TYPE;
      bytes_left_nxt   = 16'd0;
      headers_left_nxt = 16'd0;
      hdr_cnt_nxt      = 16'd0;
      low_half_nxt     = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TYPE;
      bytes_left_r   <= 16'd0;
      headers_left_r <= 16'd0;
      hdr_cnt_r      <= 16'd0;
      low_half_r     <= 8'd0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      headers_left_r <= headers_left_nxt;
      hdr_cnt_r      <= hdr_cnt_nxt;
      low_half_r     <= low_half_nxt;
    end
  end

endmodule

@@ src/lmp_obuf.sv @@
// Result register that drives the output channel.
module lmp_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lmp_pkg::lmp_res_t res,
  output logic              can_load,
  lmp_out_if.source         out_ch
);

  logic              valid_r;
  lmp_pkg::lmp_res_t res_r;

  // take a new beat when empty or when the held one leaves this cycle
  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.role          = res_r.role;
  assign out_ch.byte_out      = res_r.byte_out;
  assign out_ch.header_number = res_r.header_number;
  assign out_ch.field_done    = res_r.field_done;
  assign out_ch.status        = res_r.status;

endmodule

@@ src/length_prefixed_message_parser.sv @@
// Top level of the length-prefixed message parser.
//
// in_ch carries one message byte per beat plus buffer_end on the final byte
// of a buffer. out_ch returns exactly one tagged beat per input beat, in order:
// role, the byte itself, header index, field-done flag and status.
// Latency: a result appears on out_ch the cycle after its byte is accepted.
// Throughput: one byte per cycle unless out_ch stalls; the parser state updates
// in the same cycle the byte is taken, so back-to-back bytes need no bubbles.
// in_ch.ready stays high while the result register is empty or being drained
// in the same cycle; when the receiver stalls, the held result stays put and
// in_ch.ready drops until it is taken.
// Reset (rst_n low, synchronous) empties the result register and returns the
// parser to expect a type byte. A byte with buffer_end also returns it there,
// with status 2 if the message had not completed.
module length_prefixed_message_parser (
  input  logic      clk,
  input  logic      rst_n,
  lmp_in_if.sink    in_ch,
  lmp_out_if.source out_ch
);

  logic              accept;
  logic              can_load;
  lmp_pkg::lmp_res_t res;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  lmp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_ch.data_byte),
    .buffer_end (in_ch.buffer_end),
    .res        (res)
  );

  lmp_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

@@ verif/tb_length_prefixed_message_parser.sv @@
// Testbench for the length-prefixed message parser: byte stimulus, tag prediction and checks.
module tb_length_prefixed_message_parser;

  typedef enum logic [3:0] {
    PH_TYPE, PH_COUNT_LO, PH_COUNT_HI, PH_KLEN_LO, PH_KLEN_HI, PH_KEY,
    PH_VLEN_LO, PH_VLEN_HI, PH_VALUE, PH_BLEN_LO, PH_BLEN_HI, PH_BODY, PH_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lmp_in_if  in_ch();
  lmp_out_if out_ch();

  length_prefixed_message_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // parser state mirror
  parse_phase_t phase;
  logic [15:0]  bytes_left;
  logic [15:0]  headers_left;
  logic [15:0]  header_counter;
  logic [7:0]   low_half;

  in_beat_t          byte_q[$];
  logic [7:0]        msg_q[$];
  lmp_pkg::lmp_res_t tag_q[$];
  lmp_pkg::lmp_res_t want;
  in_beat_t          cur;

  int n_queued = 0;
  int taken_cnt = 0;
  int offered_cnt = 0;
  int err_count = 0;
  int idle_pct = 35;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  function automatic void reset_parser();
    phase = PH_TYPE;
    bytes_left = '0;
    headers_left = '0;
    header_counter = '0;
    low_half = '0;
  endfunction

  function automatic void next_header();
    header_counter = header_counter + 16'd1;
    headers_left = headers_left - 16'd1;
    phase = (headers_left != 16'd0) ? PH_KLEN_LO : PH_BLEN_LO;
  endfunction

  function automatic lmp_pkg::lmp_res_t tag_byte(input logic [7:0] b, input logic last);
    lmp_pkg::lmp_res_t r;
    logic [15:0]       word;
    r.role = lmp_pkg::ROLE_IGNORED;
    r.byte_out = b;
    r.header_number = '0;
    r.field_done = 1'b0;
    r.status = lmp_pkg::STAT_BUSY;
    word = {b, low_half};
    case (phase)
      PH_TYPE: begin
        r.role = lmp_pkg::ROLE_TYPE;
        r.field_done = 1'b1;
        phase = PH_COUNT_LO;
      end
      PH_COUNT_LO: begin
        r.role = lmp_pkg::ROLE_COUNT;
        low_half = b;
        phase = PH_COUNT_HI;
      end
      PH_COUNT_HI: begin
        r.role = lmp_pkg::ROLE_COUNT;
        r.field_done = 1'b1;
        headers_left = word;
        header_counter = '0;
        phase = (word != 16'd0) ? PH_KLEN_LO : PH_BLEN_LO;
      end
      PH_KLEN_LO: begin
        r.role = lmp_pkg::ROLE_KEYLEN;
        r.header_number = header_counter;
        low_half = b;
        phase = PH_KLEN_HI;
      end
      PH_KLEN_HI: begin
        r.role = lmp_pkg::ROLE_KEYLEN;
        r.header_number = header_counter;
        r.field_done = 1'b1;
        bytes_left = word;
        phase = (word != 16'd0) ? PH_KEY : PH_VLEN_LO;
      end
      PH_KEY: begin
        r.role = lmp_pkg::ROLE_KEY;
        r.header_number = header_counter;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin
          r.field_done = 1'b1;
          phase = PH_VLEN_LO;
        end
      end
      PH_VLEN_LO: begin
        r.role = lmp_pkg::ROLE_VALLEN;
        r.header_number = header_counter;
        low_half = b;
        phase = PH_VLEN_HI;
      end
      PH_VLEN_HI: begin
        r.role = lmp_pkg::ROLE_VALLEN;
        r.header_number = header_counter;
        r.field_done = 1'b1;
        bytes_left = word;
        if (word != 16'd0) phase = PH_VALUE;
        else next_header();
      end
      PH_VALUE: begin
        r.role = lmp_pkg::ROLE_VALUE;
        r.header_number = header_counter;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin
          r.field_done = 1'b1;
          next_header();
        end
      end
      PH_BLEN_LO: begin
        r.role = lmp_pkg::ROLE_BODYLEN;
        low_half = b;
        phase = PH_BLEN_HI;
      end
      PH_BLEN_HI: begin
        r.role = lmp_pkg::ROLE_BODYLEN;
        r.field_done = 1'b1;
        bytes_left = word;
        if (word != 16'd0) begin
          phase = PH_BODY;
        end else begin
          phase = PH_DONE;
          r.status = lmp_pkg::STAT_DONE;
        end
      end
      PH_BODY: begin
        r.role = lmp_pkg::ROLE_BODY;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin
          r.field_done = 1'b1;
          phase = PH_DONE;
          r.status = lmp_pkg::STAT_DONE;
        end
      end
      default: begin
        r.status = lmp_pkg::STAT_DONE;
      end
    endcase
    if (last) begin
      if (r.status == lmp_pkg::STAT_BUSY) r.status = lmp_pkg::STAT_TRUNC;
      reset_parser();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s got %0h want %0h (byte %02h)", name, got, exp_val,
                                want.byte_out));
  endtask

  // stimulus building
  task automatic add_len(input logic [15:0] v);
    msg_q = {msg_q, v[7:0]};
    msg_q = {msg_q, v[15:8]};
  endtask

  task automatic add_data(input int n);
    repeat (n) msg_q = {msg_q, 8'($urandom_range(255))};
  endtask

  task automatic flush_msg(input bit with_end);
    in_beat_t bt;
    int i;
    for (i = 0; i < msg_q.size(); i++) begin
      bt.data = msg_q[i];
      bt.last = with_end && (i == msg_q.size() - 1);
      byte_q = {byte_q, bt};
      n_queued++;
    end
    msg_q.delete();
  endtask

  // big: length fields take random 16-bit values but only a few data bytes follow,
  // so the parser sees a misaligned stream up to the buffer end
  task automatic add_message(input int n_hdr, input int max_len, input bit big,
                             input int n_trail, input bit cut, input bit with_end);
    int i;
    int k;
    int keep;
    logic [15:0] len;
    msg_q = {msg_q, 8'($urandom_range(255))};
    add_len(big ? 16'($urandom_range(65535)) : 16'(n_hdr));
    for (i = 0; i < n_hdr; i++) begin
      for (k = 0; k < 2; k++) begin
        len = big ? 16'($urandom_range(65535)) : 16'($urandom_range(max_len));
        add_len(len);
        add_data((big && len > 16'd6) ? 6 : int'(len));
      end
    end
    len = big ? 16'($urandom_range(65535)) : 16'($urandom_range(max_len));
    add_len(len);
    add_data((big && len > 16'd6) ? 6 : int'(len));
    add_data(n_trail);
    if (cut && msg_q.size() > 1) begin
      keep = $urandom_range(msg_q.size() - 1, 1);
      while (msg_q.size() > keep) msg_q.delete(msg_q.size() - 1);
    end
    flush_msg(with_end);
  endtask

  task automatic add_random(input int n);
    int target;
    int k;
    target = n_queued + n;
    while (n_queued < target) begin
      k = $urandom_range(99);
      if (k < 60) begin
        add_message($urandom_range(3), ($urandom_range(9) == 0) ? 12 : 4, 1'b0,
                    $urandom_range(2), 1'b0, $urandom_range(9) != 0);
      end else if (k < 78) begin
        add_message($urandom_range(3), 4, 1'b0, 0, 1'b1, 1'b1);
      end else if (k < 90) begin
        add_message($urandom_range(2), 4, 1'b1, 0, 1'b0, 1'b1);
      end else begin
        add_data($urandom_range(8, 1));
        flush_msg(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (byte_q.size() != 0 || in_ch.valid || tag_q.size() != 0);
  endtask

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (taken_cnt == offered_cnt) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = byte_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= cur.data;
        in_ch.buffer_end <= cur.last;
        offered_cnt++;
      end else begin
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= 8'($urandom_range(255));
        in_ch.buffer_end <= 1'($urandom_range(1));
      end
    end
  end

  // result-side ready, with a long hold-off each time hold_req toggles
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 60;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // predict on every accepted byte, check every accepted result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tag_q = {tag_q, tag_byte(in_ch.data_byte, in_ch.buffer_end)};
        taken_cnt <= taken_cnt + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tag_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat role %0d byte %02h", out_ch.role,
                                    out_ch.byte_out));
        end else begin
          want = tag_q.pop_front();
          check_field("role", out_ch.role, want.role);
          check_field("byte_out", out_ch.byte_out, want.byte_out);
          check_field("header_number", out_ch.header_number, want.header_number);
          check_field("field_done", out_ch.field_done, want.field_done);
          check_field("status", out_ch.status, want.status);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.buffer_end = 1'b0;
    out_ch.ready = 1'b0;
    reset_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no headers, empty body, buffer ends on the completing byte
    msg_q = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    flush_msg(1'b1);
    // empty key and value, one body byte, then ignored bytes up to the end
    msg_q = {8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
             8'hFF, 8'h00, 8'hFF};
    flush_msg(1'b1);
    // buffer ends on the type byte
    msg_q = {8'h5A};
    flush_msg(1'b1);
    // truncated after the value, before the body length
    msg_q = {8'hA5, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h7E};
    flush_msg(1'b1);
    wait_drained();

    add_random(250);
    wait_drained();

    idle_pct = 0;
    add_random(150);
    wait_drained();

    // receiver stalls while the sender keeps offering
    hold_req = ~hold_req;
    add_random(100);
    wait_drained();

    idle_pct = 35;
    add_random(200);
    wait_drained();

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS length_prefixed_message_parser");
    end else begin
      $display("FAIL length_prefixed_message_parser");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("FAIL length_prefixed_message_parser");
    $finish;
  end

endmodule

@@ files.f @@
src/lmp_pkg.sv
src/lmp_if.sv
src/lmp_core.sv
src/lmp_obuf.sv
src/length_prefixed_message_parser.sv
verif/tb_length_prefixed_message_parser.sv
